// ===== sv/llg_pkg.sv =====
package llg_pkg;

  // Field widths fixed by the interface.
  localparam int SCORE_W = 16;
  localparam int SCALE_W = 16;
  localparam int GRAD_W  = 16;
  localparam int LOSS_W  = 40;

  // Number format of the score and layout of the activation tables.
  localparam int SCORE_FRAC_BITS = 10;
  localparam int TABLE_ENTRIES   = 256;
  localparam int IDX_BITS        = $clog2(TABLE_ENTRIES);
  localparam int TIDX_W          = IDX_BITS + 1;
  localparam int U_SPAN_LOG2     = 4;
  localparam int RANGE_BITS      = U_SPAN_LOG2 + SCORE_FRAC_BITS;
  localparam int STEP_BITS       = RANGE_BITS - IDX_BITS;

  // Internal datapath widths.
  localparam int MAG_W   = SCORE_W + 1;
  localparam int Q_FRAC  = 30;
  localparam int TAB_W   = Q_FRAC + 1;
  localparam int SHIFT   = Q_FRAC - SCORE_FRAC_BITS;
  localparam int SOFTQ_W = MAG_W + SHIFT + 1;
  localparam int SOFT_W  = MAG_W + 1;
  localparam int Q_W     = TAB_W + 2;
  localparam int PROD_W  = Q_W + STEP_BITS;
  localparam int GMAG_W  = TAB_W + SCALE_W;
  localparam int GRND_W  = GMAG_W - Q_FRAC;

  localparam int ACC_BITS_DEF = 40;
  localparam int MID_DEPTH    = 4;
  localparam int OUT_DEPTH    = 8;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd4096;
  localparam logic [TAB_W-1:0]          ONE_Q       = TAB_W'(1) << Q_FRAC;
  localparam logic [LOSS_W-1:0]         LOSS_MAX    = {LOSS_W{1'b1}};

  localparam logic [63:0] Q30_ONE_64      = 64'd1 << 30;
  localparam logic [63:0] EXP_NEG_ONE_Q30 = 64'd395007542;

  typedef logic [TAB_W-1:0] tab_word_t;
  typedef tab_word_t [TABLE_ENTRIES:0] tab_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      label;
    logic                      last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic [LOSS_W-1:0]        loss_total;
    logic                     total_valid;
  } out_item_t;

  // Item after classification: magnitude of the signed argument, its sign,
  // and the table position it falls on.
  typedef struct packed {
    logic [MAG_W-1:0]     abs_z;
    logic                 zneg;
    logic                 beyond;
    logic [TIDX_W-1:0]    idx;
    logic [STEP_BITS-1:0] frac;
    logic                 label;
    logic                 last_element;
  } class_item_t;

  // The functions below only build the constant tables during elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-u with u in Q16, result in Q30.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] u);
    logic [63:0] whole;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] sum;
    whole = u >> 16;
    f     = u & 64'hFFFF;
    term  = Q30_ONE_64;
    sum   = Q30_ONE_64;
    for (int n = 1; n < 40 && term != 64'd0; n++) begin
      term = udiv64((term * f) >> 16, 64'(n));
      sum  = sum + term;
    end
    for (int k = 0; 64'(k) < whole; k++) begin
      sum = (sum * EXP_NEG_ONE_Q30) >> 30;
    end
    return sum;
  endfunction

  // ln(1 + v) in Q30 through 2*atanh(v / (2 + v)).
  function automatic logic [63:0] ln1p_q30(input logic [63:0] v);
    logic [63:0] w;
    logic [63:0] w2;
    logic [63:0] p;
    logic [63:0] sum;
    w   = udiv64(v << 30, (64'd2 << 30) + v);
    w2  = (w * w) >> 30;
    p   = w;
    sum = '0;
    for (int k = 0; k < 40 && p != 64'd0; k++) begin
      sum = sum + udiv64(p, 64'(2 * k + 1));
      p   = (p * w2) >> 30;
    end
    return sum << 1;
  endfunction

  function automatic logic [63:0] table_u(input int i);
    logic [63:0] u;
    u = (64'(i) << (U_SPAN_LOG2 + 16)) / TABLE_ENTRIES;
    return u;
  endfunction

  function automatic tab_t build_soft_tab();
    tab_t t;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      t[i] = TAB_W'(ln1p_q30(exp_neg_q30(table_u(i))));
    end
    return t;
  endfunction

  function automatic tab_t build_sig_tab();
    tab_t        t;
    logic [63:0] v;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      v    = exp_neg_q30(table_u(i));
      t[i] = TAB_W'(udiv64(v << 30, Q30_ONE_64 + v));
    end
    return t;
  endfunction

  // Samples of ln(1 + e^-u) and 1/(1 + e^u) for u on [0, 16].
  localparam tab_t SOFT_TAB = build_soft_tab();
  localparam tab_t SIG_TAB  = build_sig_tab();

endpackage

// ===== sv/llg_fifo.sv =====
module llg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = push & ~full;
  assign do_rd = pop & ~empty;
  assign rdata = mem[rptr_r];

  always_comb begin
    wptr_nxt  = do_wr ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt  = do_rd ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = CNT_W'(count_r + CNT_W'(do_wr) - CNT_W'(do_rd));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/llg_front.sv =====
module llg_front import llg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  output logic        q_push,
  output class_item_t q_item,
  input  logic        q_full
);

  logic [MAG_W-1:0] zx;
  logic [MAG_W-1:0] z;
  logic [MAG_W-1:0] abs_z;
  class_item_t      cls;
  class_item_t      item_r;
  logic             valid_r, valid_nxt;
  logic             accept;

  // The label flips the sign of the score; the magnitude picks the table slot.
  always_comb begin
    zx    = {in_data.score[SCORE_W-1], in_data.score};
    z     = in_data.label ? MAG_W'(~zx + 1'b1) : zx;
    abs_z = z[MAG_W-1] ? MAG_W'(~z + 1'b1) : z;

    cls.abs_z        = abs_z;
    cls.zneg         = z[MAG_W-1];
    cls.beyond       = |abs_z[MAG_W-1:RANGE_BITS];
    cls.idx          = cls.beyond ? TIDX_W'(TABLE_ENTRIES)
                                  : {1'b0, abs_z[STEP_BITS +: IDX_BITS]};
    cls.frac         = abs_z[STEP_BITS-1:0];
    cls.label        = in_data.label;
    cls.last_element = in_data.last_element;
  end

  assign full      = valid_r & q_full;
  assign accept    = push & ~full;
  assign valid_nxt = accept | (valid_r & q_full);
  assign q_push    = valid_r;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= cls;
    end
  end

endmodule

// ===== sv/llg_back.sv =====
module llg_back import llg_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic signed [SCALE_W-1:0] cfg_data,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  class_item_t               q_item,
  output logic                      out_push,
  output out_item_t                 out_item,
  input  logic                      out_taken
);

  localparam int USED_W = $clog2(OUT_DEPTH + 1);
  localparam int WIDE_W = (ACC_BITS > LOSS_W) ? ACC_BITS : LOSS_W;
  localparam logic [GRND_W-1:0] GRAD_POS_MAX = GRND_W'((1 << (GRAD_W - 1)) - 1);
  localparam logic [GRND_W-1:0] GRAD_NEG_MAX = GRND_W'(1 << (GRAD_W - 1));

  typedef struct packed {
    logic [MAG_W-1:0] abs_z;
    logic             zneg;
    logic             label;
    logic             last_element;
  } carry_t;

  function automatic logic [TAB_W-1:0] interp_pt(
    input logic [TAB_W-1:0]     a,
    input logic signed [TAB_W:0] d,
    input logic [STEP_BITS-1:0] frac,
    input logic                 clamp_hi
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    val;
    logic [TAB_W-1:0]         res;
    prod = $signed({{(PROD_W - TAB_W - 1){d[TAB_W]}}, d})
         * $signed({{(PROD_W - STEP_BITS){1'b0}}, frac});
    // Bias negative products so the shift truncates toward zero.
    biased = prod[PROD_W-1] ? prod + $signed(PROD_W'((1 << STEP_BITS) - 1)) : prod;
    q      = Q_W'(biased >>> STEP_BITS);
    val    = $signed({2'b00, a}) + q;
    if (val[Q_W-1]) begin
      res = '0;
    end else if (clamp_hi && (val[TAB_W:0] > {1'b0, ONE_Q})) begin
      res = ONE_Q;
    end else begin
      res = val[TAB_W-1:0];
    end
    return res;
  endfunction

  logic signed [SCALE_W-1:0] scale_r;
  logic [USED_W-1:0]         used_r, used_nxt;
  logic [ACC_BITS-1:0]       acc_r, acc_nxt;
  logic                      issue;

  logic                      s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  class_item_t               s1_r;

  logic [TIDX_W-1:0]         idx_hi;
  logic [TAB_W-1:0]          g_a, g_b, h_a, h_b;
  logic [TAB_W-1:0]          g_a_r, h_a_r;
  logic signed [TAB_W:0]     g_d_r, h_d_r;
  logic [STEP_BITS-1:0]      s2_frac_r;
  carry_t                    s2_c_r;

  logic [TAB_W-1:0]          g_r, h_r;
  carry_t                    s3_c_r;

  logic [SOFTQ_W-1:0]        soft_q;
  logic [SOFT_W-1:0]         sp_rnd, sp_rnd_r;
  logic [TAB_W-1:0]          sig, sig_r;
  logic                      s4_label_r, s4_last_r;

  logic [ACC_BITS:0]         acc_sum;
  logic [ACC_BITS-1:0]       acc_sat;
  logic [WIDE_W-1:0]         acc_wide;
  logic [LOSS_W-1:0]         total;
  logic [SCALE_W-1:0]        abs_scale;
  logic [GMAG_W-1:0]         mag_r;
  logic                      neg_r;
  logic [LOSS_W-1:0]         total_r;
  logic                      s5_last_r;

  logic [GRND_W-1:0]         mag_rnd;
  logic signed [GRAD_W-1:0]  grad;

  // Credit check: every issued item has a reserved slot in the result queue.
  assign issue    = ~q_empty & (used_r < USED_W'(OUT_DEPTH));
  assign q_pop    = issue;
  assign used_nxt = USED_W'(used_r + USED_W'(issue) - USED_W'(out_taken));

  // Table read at both ends of the interval.
  always_comb begin
    idx_hi = s1_r.beyond ? s1_r.idx : TIDX_W'(s1_r.idx + 1'b1);
    g_a    = SOFT_TAB[s1_r.idx];
    g_b    = SOFT_TAB[idx_hi];
    h_a    = SIG_TAB[s1_r.idx];
    h_b    = SIG_TAB[idx_hi];
  end

  // Softplus rounding and sigmoid side selection.
  always_comb begin
    soft_q = s3_c_r.zneg ? SOFTQ_W'(g_r)
                         : SOFTQ_W'((SOFTQ_W'(s3_c_r.abs_z) << SHIFT) + SOFTQ_W'(g_r));
    sp_rnd = SOFT_W'((soft_q + (SOFTQ_W'(1) << (SHIFT - 1))) >> SHIFT);
    sig    = s3_c_r.zneg ? h_r : TAB_W'(ONE_Q - h_r);
  end

  // Saturating sum and batch total.
  always_comb begin
    acc_sum   = {1'b0, acc_r} + (ACC_BITS + 1)'(sp_rnd_r);
    acc_sat   = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];
    acc_wide  = WIDE_W'(acc_sat);
    total     = (acc_wide > WIDE_W'(LOSS_MAX)) ? LOSS_MAX : acc_wide[LOSS_W-1:0];
    acc_nxt   = acc_r;
    if (s4_v_r) begin
      acc_nxt = s4_last_r ? '0 : acc_sat;
    end
    abs_scale = scale_r[SCALE_W-1] ? SCALE_W'(-scale_r) : scale_r;
  end

  // Gradient rounding, sign and saturation.
  always_comb begin
    mag_rnd = GRND_W'((mag_r + (GMAG_W'(1) << (Q_FRAC - 1))) >> Q_FRAC);
    if (!neg_r) begin
      grad = (mag_rnd > GRAD_POS_MAX) ? GRAD_W'(GRAD_POS_MAX) : GRAD_W'(mag_rnd);
    end else begin
      grad = (mag_rnd > GRAD_NEG_MAX) ? GRAD_W'(GRAD_NEG_MAX)
                                      : GRAD_W'(GRND_W'(0) - mag_rnd);
    end
    out_item.gradient    = grad;
    out_item.loss_total  = s5_last_r ? total_r : '0;
    out_item.total_valid = s5_last_r;
  end

  assign out_push = s5_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      used_r  <= '0;
      acc_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_data;
      end
      used_r <= used_nxt;
      acc_r  <= acc_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= q_item;
    end
    g_a_r     <= g_a;
    h_a_r     <= h_a;
    g_d_r     <= $signed({1'b0, g_b}) - $signed({1'b0, g_a});
    h_d_r     <= $signed({1'b0, h_b}) - $signed({1'b0, h_a});
    s2_frac_r <= s1_r.frac;
    s2_c_r    <= '{abs_z: s1_r.abs_z, zneg: s1_r.zneg, label: s1_r.label,
                   last_element: s1_r.last_element};

    g_r    <= interp_pt(g_a_r, g_d_r, s2_frac_r, 1'b0);
    h_r    <= interp_pt(h_a_r, h_d_r, s2_frac_r, 1'b1);
    s3_c_r <= s2_c_r;

    sp_rnd_r   <= sp_rnd;
    sig_r      <= sig;
    s4_label_r <= s3_c_r.label;
    s4_last_r  <= s3_c_r.last_element;

    mag_r     <= GMAG_W'(sig_r) * GMAG_W'(abs_scale);
    neg_r     <= s4_label_r ^ scale_r[SCALE_W-1];
    total_r   <= total;
    s5_last_r <= s4_last_r;
  end

endmodule

// ===== sv/logistic_loss_and_gradient_core.sv =====
// An accepted input beat passes the front register, the classified-item queue and the back end.
// Throughput: one item per cycle while result slots are free, set by the five-stage back pipeline
// and the 8-entry result queue whose free slots are reserved before an item enters the pipeline.
// Reset (rst_n low, synchronous): both queues empty, loss sum cleared, gradient_scale = 1.0.
// The activation tables are constants, so no clearing pass follows reset.
module logistic_loss_and_gradient_core import llg_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel: a beat is taken when push is high and full is low.
  input  logic                      push,
  output logic                      full,
  input  in_item_t                  in_data,
  // Result channel: the head result is shown while empty is low.
  output logic                      empty,
  input  logic                      pop,
  output out_item_t                 out_data,
  // Configuration: gradient_scale, written on a valid and ready beat.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic signed [SCALE_W-1:0] cfg_data
);

  class_item_t f_item;
  class_item_t q_item;
  logic        f_push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  out_item_t   b_item;
  logic        out_push;
  logic        out_full;
  logic        out_taken;

  // The scale register is a plain register with no side effects, so every
  // configuration beat is taken at once.
  assign cfg_ready = 1'b1;
  assign out_taken = pop & ~empty;

  // Front end: computes the signed argument, its magnitude, and the table
  // slot, then holds the classified item in a single register stage. It only
  // stalls when the classified-item queue is full.
  llg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_push (f_push),
    .q_item (f_item),
    .q_full (q_full)
  );

  // Short queue between the front and back ends so that each side can stall
  // without holding up the other.
  llg_fifo #(
    .WIDTH($bits(class_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_push),
    .wdata(f_item),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_item),
    .empty(q_empty)
  );

  // Back end: table read, interpolation, softplus and sigmoid assembly, then
  // the loss sum and the gradient multiply, then rounding and saturation.
  // The pipeline never stalls. An item only leaves the queue once a slot in
  // the result queue has been reserved for it.
  llg_back #(
    .ACC_BITS(ACC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .out_push (out_push),
    .out_item (b_item),
    .out_taken(out_taken)
  );

  // Result queue. It decouples the pipeline from the consumer so that a
  // finished result can wait while new items keep flowing in.
  llg_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (out_push),
    .wdata(b_item),
    .full (out_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

  // The slot reservation must ensure that a finished result always finds room.
  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result queue written while full");

  // After reset both channels start out idle.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("channels not idle after reset");

  // A result that does not close a batch carries a zero total.
  a_total_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.total_valid |-> out_data.loss_total == '0)
    else $error("nonzero loss total outside the last element");

endmodule
